[hw/rtl/motion_vector_outlier_filter_assert.svh]
// Assertion macros shared by the motion vector outlier filter RTL.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef MOTION_VECTOR_OUTLIER_FILTER_ASSERT_SVH
`define MOTION_VECTOR_OUTLIER_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MVOF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MVOF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mvof_pkg.sv]
// Shared constants, types and helper functions of the motion vector outlier filter.
// No dependencies; every other RTL file but the assertion header imports this package.
`default_nettype none

package mvof_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int COORD_WIDTH = 16;

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int MAG_W  = COORD_WIDTH;
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int SUM_W  = MAG_W + CNT_W;
  localparam int PROD_W = MAG_W + CNT_W;
  localparam int CMP_W  = SUM_W + 3;

  // A point whose y rose by more than three pixels (1/16 pixel units) is dropped.
  localparam int RISE_LIMIT = 48;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [1:0] class_t;

  localparam class_t CLASS_BOX   = 2'd1;
  localparam class_t CLASS_TRUCK = 2'd2;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    class_t cls;
  } point_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_MULX,
    ST_MULY,
    ST_TEST,
    ST_FLUSH
  } mvof_state_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic in_fire;
    logic in_last;
    logic idx_end;
    logic keep;
    logic have_pend;
    logic slot_free;
  } mvof_stat_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic in_ready;
    logic rd_en;
    logic mul_en;
    logic mul_sel_y;
    logic latch_x;
    logic advance;
    logic pend_load;
    logic pend_push;
    logic flush;
  } mvof_ctl_t;

  // Magnitude of the difference of two coordinates.
  function automatic logic [MAG_W-1:0] mag_diff(input coord_t a, input coord_t b);
    logic signed [DIFF_W-1:0] d;
    logic signed [DIFF_W-1:0] n;
    begin
      d = DIFF_W'(a) - DIFF_W'(b);
      n = -d;
      mag_diff = d[DIFF_W-1] ? n[MAG_W-1:0] : d[MAG_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

[hw/rtl/mvof_if.sv]
// Stream interfaces of the motion vector outlier filter: point input and result output.
// Depends on mvof_pkg for the coordinate and class types.
`default_nettype none

interface mvof_in_if import mvof_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  class_t point_class;
  logic   last;

  modport source (output valid, start_x, start_y, end_x, end_y, point_class, last,
                  input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, point_class, last,
                output ready);
endinterface

interface mvof_out_if import mvof_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t out_start_x;
  coord_t out_start_y;
  coord_t out_end_x;
  coord_t out_end_y;
  class_t out_class;
  logic   valid_res;
  logic   final_res;
  logic   overflow;

  modport source (output valid, out_start_x, out_start_y, out_end_x, out_end_y, out_class,
                  valid_res, final_res, overflow, input ready);
  modport sink (input valid, out_start_x, out_start_y, out_end_x, out_end_y, out_class,
                valid_res, final_res, overflow, output ready);
endinterface

`default_nettype wire

[hw/rtl/mvof_store.sv]
// Point store: one write port and one registered read port.
// Depends on mvof_pkg for the point type and depth.
`default_nettype none

module mvof_store import mvof_pkg::*; (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  point_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output point_t           rd_data_r
);

  point_t mem [MAX_POINTS];

  // Write side.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mvof_mul.sv]
// Shared displacement multiplier: |start - end| of one axis times a class count.
// Depends on mvof_pkg for widths and the magnitude helper.
`default_nettype none

module mvof_mul import mvof_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic              sel_y,
  input  point_t            pt,
  input  logic [CNT_W-1:0]  cnt,
  output logic [PROD_W-1:0] prod_r
);

  coord_t           op_a;
  coord_t           op_b;
  logic [MAG_W-1:0] mag;

  // Pick the axis, then form the displacement magnitude.
  always_comb begin
    op_a = sel_y ? pt.sy : pt.sx;
    op_b = sel_y ? pt.ey : pt.ex;
    mag  = mag_diff(op_a, op_b);
  end

  // One product per enabled cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(mag) * PROD_W'(cnt);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mvof_ctrl.sv]
// Sequencer of the filter: loading, then a per-point read, multiply and test pass, then a flush.
// Depends on mvof_pkg for the state, status and control types.
`default_nettype none

module mvof_ctrl import mvof_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  mvof_stat_t stat,
  output mvof_ctl_t  ctl
);

  mvof_state_t state_r;
  mvof_state_t state_nxt;
  logic        test_stall;

  // A kept point waits while the pending one cannot move to the output register.
  assign test_stall = stat.keep && stat.have_pend && !stat.slot_free;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (stat.in_fire && stat.in_last) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = stat.idx_end ? ST_FLUSH : ST_MULX;
      end
      ST_MULX: state_nxt = ST_MULY;
      ST_MULY: state_nxt = ST_TEST;
      ST_TEST: begin
        if (!test_stall) state_nxt = ST_READ;
      end
      ST_FLUSH: begin
        if (stat.slot_free) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Outputs.
  always_comb begin
    ctl = '0;
    case (state_r)
      ST_LOAD: ctl.in_ready = 1'b1;
      ST_READ: ctl.rd_en = !stat.idx_end;
      ST_MULX: begin
        ctl.mul_en    = 1'b1;
        ctl.mul_sel_y = 1'b0;
      end
      ST_MULY: begin
        ctl.mul_en    = 1'b1;
        ctl.mul_sel_y = 1'b1;
        ctl.latch_x   = 1'b1;
      end
      ST_TEST: begin
        if (!test_stall) begin
          ctl.advance   = 1'b1;
          ctl.pend_load = stat.keep;
          ctl.pend_push = stat.keep && stat.have_pend;
        end
      end
      ST_FLUSH: ctl.flush = stat.slot_free;
      default: ctl = '0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/motion_vector_outlier_filter.sv]
// Loading takes one item per cycle; items past the store's capacity are taken and dropped.
// The last item starts a pass: each stored point gets a store read, two products on the
// one shared multiplier and a test; a final read detects the end and a flush emits the
// final result. Survivor pushes and the flush wait while the output stalls. Survivors
// wait for the next survivor or the flush. Synchronous reset clears counts, sums and
// flags; the point store is not cleared and only entries of the current set are read.
`default_nettype none
`include "motion_vector_outlier_filter_assert.svh"

module motion_vector_outlier_filter import mvof_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  mvof_in_if.sink   in_pt,
  mvof_out_if.source out_res
);

  localparam logic signed [DIFF_W-1:0] RiseMin = DIFF_W'(-RISE_LIMIT);

  mvof_stat_t stat;
  mvof_ctl_t  ctl;

  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] box_cnt_r;
  logic [CNT_W-1:0] truck_cnt_r;
  logic [SUM_W-1:0] box_sdx_r;
  logic [SUM_W-1:0] box_sdy_r;
  logic [SUM_W-1:0] truck_sdx_r;
  logic [SUM_W-1:0] truck_sdy_r;
  logic             ovf_r;
  logic             have_pend_r;
  point_t           pend_r;
  logic             out_valid_r;
  point_t           out_pt_r;
  logic             out_vres_r;
  logic             out_final_r;
  logic             out_ovf_r;
  logic [PROD_W-1:0] prod_x_r;

  logic              in_fire;
  logic              room;
  point_t            in_point;
  logic [MAG_W-1:0]  ld_dx;
  logic [MAG_W-1:0]  ld_dy;
  point_t            rd_pt;
  logic [PROD_W-1:0] mul_prod;
  logic [CNT_W-1:0]  mul_cnt;
  logic              slot_free;

  logic signed [DIFF_W-1:0] ry;
  logic             rise;
  logic [CMP_W-1:0] px, py, px3, py3, px4;
  logic [CMP_W-1:0] sdx, sdy, sdx4, sdy3, sdy4;
  logic             box_drop;
  logic             truck_drop;
  logic             keep;

  // Input side.
  assign in_fire = in_pt.valid && ctl.in_ready;
  assign room    = fill_r < CNT_W'(MAX_POINTS);
  assign in_point = '{sx: in_pt.start_x, sy: in_pt.start_y, ex: in_pt.end_x,
                      ey: in_pt.end_y, cls: in_pt.point_class};
  assign ld_dx = mag_diff(in_pt.start_x, in_pt.end_x);
  assign ld_dy = mag_diff(in_pt.start_y, in_pt.end_y);
  assign in_pt.ready = ctl.in_ready;

  assign slot_free = !out_valid_r || out_res.ready;

  mvof_store u_store (
    .clk       (clk),
    .wr_en     (in_fire && room),
    .wr_addr   (fill_r[IDX_W-1:0]),
    .wr_data   (in_point),
    .rd_en     (ctl.rd_en),
    .rd_addr   (idx_r[IDX_W-1:0]),
    .rd_data_r (rd_pt)
  );

  // Count of the read point's class feeds the multiplier.
  always_comb begin
    case (rd_pt.cls)
      CLASS_BOX:   mul_cnt = box_cnt_r;
      CLASS_TRUCK: mul_cnt = truck_cnt_r;
      default:     mul_cnt = '0;
    endcase
  end

  mvof_mul u_mul (
    .clk    (clk),
    .en     (ctl.mul_en),
    .sel_y  (ctl.mul_sel_y),
    .pt     (rd_pt),
    .cnt    (mul_cnt),
    .prod_r (mul_prod)
  );

  // Outlier tests, cross-multiplied with the class count.
  always_comb begin
    ry   = DIFF_W'(rd_pt.sy) - DIFF_W'(rd_pt.ey);
    rise = ry < RiseMin;
    px   = CMP_W'(prod_x_r);
    py   = CMP_W'(mul_prod);
    px3  = px + (px << 1);
    py3  = py + (py << 1);
    px4  = px << 2;
    sdx  = CMP_W'((rd_pt.cls == CLASS_TRUCK) ? truck_sdx_r : box_sdx_r);
    sdy  = CMP_W'((rd_pt.cls == CLASS_TRUCK) ? truck_sdy_r : box_sdy_r);
    sdx4 = sdx << 2;
    sdy3 = sdy + (sdy << 1);
    sdy4 = sdy << 2;
    box_drop   = (py > sdy3) || (px > sdx4) || (px3 < sdx);
    truck_drop = (py > sdy4) || (px > sdx4) || (py3 < sdy) || (px4 < sdx);
    keep = !rise && !((rd_pt.cls == CLASS_BOX) && box_drop)
                 && !((rd_pt.cls == CLASS_TRUCK) && truck_drop);
  end

  always_comb begin
    stat.in_fire   = in_fire;
    stat.in_last   = in_pt.last;
    stat.idx_end   = idx_r == fill_r;
    stat.keep      = keep;
    stat.have_pend = have_pend_r;
    stat.slot_free = slot_free;
  end

  mvof_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  // Set accumulation while loading; cleared when the pass ends.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.flush) begin
      fill_r      <= '0;
      box_cnt_r   <= '0;
      truck_cnt_r <= '0;
      box_sdx_r   <= '0;
      box_sdy_r   <= '0;
      truck_sdx_r <= '0;
      truck_sdy_r <= '0;
      ovf_r       <= 1'b0;
    end else if (in_fire) begin
      if (room) begin
        fill_r <= fill_r + CNT_W'(1);
        if (in_pt.point_class == CLASS_BOX) begin
          box_cnt_r <= box_cnt_r + CNT_W'(1);
          box_sdx_r <= box_sdx_r + SUM_W'(ld_dx);
          box_sdy_r <= box_sdy_r + SUM_W'(ld_dy);
        end else if (in_pt.point_class == CLASS_TRUCK) begin
          truck_cnt_r <= truck_cnt_r + CNT_W'(1);
          truck_sdx_r <= truck_sdx_r + SUM_W'(ld_dx);
          truck_sdy_r <= truck_sdy_r + SUM_W'(ld_dy);
        end
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // Pass index and the held-back survivor.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.flush) begin
      idx_r       <= '0;
      have_pend_r <= 1'b0;
    end else begin
      if (ctl.advance) idx_r <= idx_r + CNT_W'(1);
      if (ctl.pend_load) have_pend_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pend_load) pend_r <= rd_pt;
    if (ctl.latch_x) prod_x_r <= mul_prod;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.pend_push || ctl.flush) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pend_push) begin
      out_pt_r    <= pend_r;
      out_vres_r  <= 1'b1;
      out_final_r <= 1'b0;
      out_ovf_r   <= ovf_r;
    end else if (ctl.flush) begin
      out_pt_r    <= have_pend_r ? pend_r : '0;
      out_vres_r  <= have_pend_r;
      out_final_r <= 1'b1;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.out_start_x = out_pt_r.sx;
  assign out_res.out_start_y = out_pt_r.sy;
  assign out_res.out_end_x   = out_pt_r.ex;
  assign out_res.out_end_y   = out_pt_r.ey;
  assign out_res.out_class   = out_pt_r.cls;
  assign out_res.valid_res   = out_vres_r;
  assign out_res.final_res   = out_final_r;
  assign out_res.overflow    = out_ovf_r;

  // Checks on the pass and the output register.
  `MVOF_ASSERT_NEXT(a_flush_final, ctl.flush, out_valid_r && out_final_r,
                    "flush did not present a final item")
  `MVOF_ASSERT_SAME(a_push_has_pend, ctl.pend_push, have_pend_r,
                    "pending point pushed while none is held")
  `MVOF_ASSERT_SAME(a_idx_in_range, !ctl.in_ready, idx_r <= fill_r,
                    "pass index ran past the stored points")
  `MVOF_ASSERT_SAME(a_no_overwrite, out_valid_r && !out_res.ready,
                    !(ctl.pend_push || ctl.flush),
                    "stalled output item overwritten")

endmodule

`default_nettype wire
